// ===== hw/rtl/crt_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package crt_pkg;

	localparam int IDX_W = 10;
	localparam int ADDR_W = 32;
	localparam int DEPTH_W = 6;
	localparam int FC_W = 11;
	localparam int CFG_IDX_W = 1;
	localparam int CFG_DATA_W = 11;

	localparam logic [31:0] RET_ENCODING = 32'h0000_8067;

	localparam logic OP_LOAD = 1'b0;
	localparam logic OP_JUMP = 1'b1;

	localparam logic EV_CALL = 1'b0;
	localparam logic EV_RETURN = 1'b1;

	localparam logic [CFG_IDX_W-1:0] REG_TRACE_ENABLE = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_FUNCTION_COUNT = 1'd1;

	typedef struct packed {
		logic              opcode;
		logic [IDX_W-1:0]  entry_index;
		logic [ADDR_W-1:0] entry_start;
		logic [ADDR_W-1:0] entry_size;
		logic [ADDR_W-1:0] jump_target;
		logic [ADDR_W-1:0] jump_pc;
		logic [31:0]       instr_word;
	} req_t;

	typedef struct packed {
		logic               event_kind;
		logic [IDX_W-1:0]   func_index;
		logic [ADDR_W-1:0]  func_start;
		logic [ADDR_W-1:0]  event_pc;
		logic [DEPTH_W-1:0] call_depth;
		logic               last_of_run;
	} res_t;

	typedef struct packed {
		logic walk_dec;
		logic set_match;
		logic emit_ret;
		logic emit_dec;
		logic pop;
		logic search_step;
		logic emit_call;
	} ctrl_cmd_t;

	typedef struct packed {
		logic is_load;
		logic is_ret;
		logic trace_en;
		logic in_range;
		logic walk_end;
		logic last;
		logic hit;
		logic exhausted;
	} ctrl_sts_t;

endpackage

`default_nettype wire

// ===== hw/rtl/crt_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none

module crt_ctrl
	import crt_pkg::*;
(
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      accept,
	input  wire ctrl_sts_t sts,
	output ctrl_cmd_t      cmd,
	output logic           busy
);

	typedef enum logic [2:0] {
		S_IDLE,
		S_WALK_RD,
		S_WALK_SZ,
		S_WALK_CMP,
		S_EMIT_RD,
		S_EMIT_OUT,
		S_SEARCH
	} state_t;

	state_t state_q;
	logic busy_q;

	always_comb begin
		cmd = '0;
		unique case (state_q)
			S_WALK_CMP: begin
				cmd.walk_dec = !sts.in_range;
				cmd.set_match = sts.in_range;
			end
			S_EMIT_OUT: begin
				cmd.emit_ret = 1'b1;
				cmd.emit_dec = !sts.last;
				cmd.pop = sts.last;
			end
			S_SEARCH: begin
				cmd.search_step = !sts.hit;
				cmd.emit_call = sts.hit;
			end
			default: begin
				cmd = '0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			busy_q <= 1'b0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						priority if (sts.is_load || !sts.trace_en) begin
							state_q <= S_IDLE;
							busy_q <= 1'b0;
						end else if (sts.is_ret) begin
							state_q <= S_WALK_RD;
							busy_q <= 1'b1;
						end else begin
							state_q <= S_SEARCH;
							busy_q <= 1'b1;
						end
					end
				end
				S_WALK_RD: begin
					state_q <= S_WALK_SZ;
				end
				S_WALK_SZ: begin
					state_q <= S_WALK_CMP;
				end
				S_WALK_CMP: begin
					priority if (sts.in_range) begin
						state_q <= S_EMIT_RD;
					end else if (sts.walk_end) begin
						state_q <= S_SEARCH;
					end else begin
						state_q <= S_WALK_RD;
					end
				end
				S_EMIT_RD: begin
					state_q <= S_EMIT_OUT;
				end
				S_EMIT_OUT: begin
					if (sts.last) begin
						state_q <= S_IDLE;
						busy_q <= 1'b0;
					end else begin
						state_q <= S_EMIT_RD;
					end
				end
				S_SEARCH: begin
					if (sts.hit || sts.exhausted) begin
						state_q <= S_IDLE;
						busy_q <= 1'b0;
					end
				end
				default: begin
					state_q <= S_IDLE;
					busy_q <= 1'b0;
				end
			endcase
		end
	end

	assign busy = busy_q;

	a_busy_tracks_state: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q == (state_q != S_IDLE))
		else $error("busy out of step with state");

	a_no_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != S_IDLE) |-> !accept)
		else $error("request taken while busy");

	a_emit_after_read: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_EMIT_OUT) |-> ($past(state_q) == S_EMIT_RD))
		else $error("return emitted without frame read");

endmodule

`default_nettype wire

// ===== hw/rtl/crt_datapath.sv =====
`timescale 1ns / 1ps
`default_nettype none

module crt_datapath
	import crt_pkg::*;
#(
	parameter int TABLE_DEPTH = 1024,
	parameter int STACK_DEPTH = 32
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  accept,
	input  wire req_t                  request,
	input  wire logic                  cfg_we,
	input  wire logic [CFG_IDX_W-1:0]  cfg_addr,
	input  wire logic [CFG_DATA_W-1:0] cfg_wdata,
	input  wire ctrl_cmd_t             cmd,
	output ctrl_sts_t                  sts,
	output res_t                       result,
	output logic                       result_valid
);

	localparam int TW = $clog2(TABLE_DEPTH);
	localparam int IW = $clog2(TABLE_DEPTH + 1);
	localparam int SA = $clog2(STACK_DEPTH);
	localparam int SW = $clog2(STACK_DEPTH + 1);
	localparam int CW = (IW > FC_W) ? IW : FC_W;
	localparam logic [31:0] TABLE_DEPTH_W = 32'(TABLE_DEPTH);

	logic [ADDR_W-1:0] table_start_mem [TABLE_DEPTH];
	logic [ADDR_W-1:0] table_size_mem [TABLE_DEPTH];
	logic [ADDR_W-1:0] frame_start_mem [STACK_DEPTH];
	logic [IDX_W-1:0]  frame_func_mem [STACK_DEPTH];

	logic              trace_enable_q;
	logic [FC_W-1:0]   function_count_q;
	logic [ADDR_W-1:0] target_q;
	logic [ADDR_W-1:0] pc_q;
	logic [SW-1:0]     n_q;
	logic [SW-1:0]     ptr_q;
	logic [SW-1:0]     match_q;
	logic [IW-1:0]     idx_q;
	logic [TW-1:0]     idx_s1;
	logic              valid_s1;
	logic [ADDR_W-1:0] start_rd_q;
	logic [ADDR_W-1:0] size_rd_q;
	logic [ADDR_W-1:0] fs_rd_q;
	logic [IDX_W-1:0]  ff_rd_q;
	res_t              result_q;
	logic              result_valid_q;

	logic [IW-1:0]   limit;
	logic [SW-1:0]   ptr_m1;
	logic [SA-1:0]   stack_addr;
	logic [ADDR_W:0] range_hi;
	logic            load_we;
	logic            in_search;

	always_comb begin
		if (CW'(function_count_q) > CW'(TABLE_DEPTH)) begin
			limit = IW'(TABLE_DEPTH);
		end else begin
			limit = IW'(function_count_q);
		end
	end

	assign ptr_m1 = ptr_q - 1'b1;
	assign stack_addr = ptr_m1[SA-1:0];
	assign range_hi = {1'b0, fs_rd_q} + {1'b0, size_rd_q};
	assign load_we = accept && (request.opcode == OP_LOAD)
		&& ({22'd0, request.entry_index} < TABLE_DEPTH_W);
	assign in_search = idx_q < limit;

	always_comb begin
		sts.is_load = request.opcode == OP_LOAD;
		sts.is_ret = (request.instr_word == RET_ENCODING) && (n_q != '0);
		sts.trace_en = trace_enable_q;
		sts.in_range = (pc_q >= fs_rd_q) && ({1'b0, pc_q} <= range_hi);
		sts.walk_end = ptr_q == SW'(1);
		sts.last = ptr_m1 == match_q;
		sts.hit = valid_s1 && (start_rd_q == target_q);
		sts.exhausted = !valid_s1 && !in_search;
	end

	// function table
	always_ff @(posedge clk) begin
		if (load_we) begin
			table_start_mem[TW'(request.entry_index)] <= request.entry_start;
			table_size_mem[TW'(request.entry_index)] <= request.entry_size;
		end
		start_rd_q <= table_start_mem[idx_q[TW-1:0]];
		size_rd_q <= table_size_mem[TW'(ff_rd_q)];
	end

	// shadow stack
	always_ff @(posedge clk) begin
		if (cmd.emit_call && (n_q < SW'(STACK_DEPTH))) begin
			frame_start_mem[n_q[SA-1:0]] <= target_q;
			frame_func_mem[n_q[SA-1:0]] <= IDX_W'(idx_s1);
		end
		fs_rd_q <= frame_start_mem[stack_addr];
		ff_rd_q <= frame_func_mem[stack_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			trace_enable_q <= 1'b1;
			function_count_q <= '0;
			n_q <= '0;
			valid_s1 <= 1'b0;
			result_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				unique case (cfg_addr)
					REG_TRACE_ENABLE: trace_enable_q <= cfg_wdata[0];
					REG_FUNCTION_COUNT: function_count_q <= cfg_wdata[FC_W-1:0];
					default: trace_enable_q <= trace_enable_q;
				endcase
			end
			if (accept) begin
				valid_s1 <= 1'b0;
			end else if (cmd.search_step) begin
				valid_s1 <= in_search;
			end
			if (cmd.pop) begin
				n_q <= match_q;
			end else if (cmd.emit_call && (n_q < SW'(STACK_DEPTH))) begin
				n_q <= n_q + 1'b1;
			end
			result_valid_q <= cmd.emit_ret || cmd.emit_call;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			target_q <= request.jump_target;
			pc_q <= request.jump_pc;
			ptr_q <= n_q;
			idx_q <= '0;
		end else begin
			if (cmd.set_match) begin
				match_q <= ptr_m1;
				ptr_q <= n_q;
			end else if (cmd.walk_dec || cmd.emit_dec) begin
				ptr_q <= ptr_m1;
			end
			if (cmd.search_step && in_search) begin
				idx_s1 <= idx_q[TW-1:0];
				idx_q <= idx_q + 1'b1;
			end
		end
		if (cmd.emit_call) begin
			result_q.event_kind <= EV_CALL;
			result_q.func_index <= IDX_W'(idx_s1);
			result_q.func_start <= start_rd_q;
			result_q.event_pc <= pc_q;
			result_q.call_depth <= DEPTH_W'(n_q);
			result_q.last_of_run <= 1'b1;
		end else if (cmd.emit_ret) begin
			result_q.event_kind <= EV_RETURN;
			result_q.func_index <= ff_rd_q;
			result_q.func_start <= fs_rd_q;
			result_q.event_pc <= pc_q;
			result_q.call_depth <= DEPTH_W'(ptr_q);
			result_q.last_of_run <= sts.last;
		end
	end

	assign result = result_q;
	assign result_valid = result_valid_q;

	a_depth_bound: assert property (@(posedge clk) disable iff (!arst_n)
		n_q <= SW'(STACK_DEPTH))
		else $error("stack count beyond depth");

	a_one_emit: assert property (@(posedge clk) disable iff (!arst_n)
		!(cmd.emit_call && cmd.emit_ret))
		else $error("call and return emitted together");

	a_pop_shrinks: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.pop |=> (n_q < $past(n_q)))
		else $error("pop did not shrink the stack");

endmodule

`default_nettype wire

// ===== hw/rtl/call_return_tracer_top.sv =====
`timescale 1ns / 1ps
`default_nettype none

// call/return tracer with a shadow call stack
// request channel: a request is taken at a clock edge with start high and busy low
// config port: cfg_wdata, cfg_addr, cfg_we write trace_enable or function_count;
// the user must write only while the block is idle, the block does not enforce it
// a load writes one function table slot if entry_index < TABLE_DEPTH, busy stays low
// a jump request with tracing off gives nothing and busy stays low
// a return with frames on the stack walks them from the top, each frame taking a
// frame read, a table size read and a range compare; a match then emits one
// return event per popped frame, each after a frame read; with no match, or
// for a call, the table is scanned one entry per cycle through its read port,
// up to function_count entries, capped at TABLE_DEPTH; a hit emits one call event
// each event shows on result for one cycle with result_valid high, in the cycle
// after it is formed; the receiver cannot stall, nothing is held back
// reset clears the stack depth, tracing on, function_count zero; the table
// and frame memories are not cleared and need no sweep
module call_return_tracer_top
	import crt_pkg::*;
#(
	parameter int TABLE_DEPTH = 1024,
	parameter int STACK_DEPTH = 32
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  start,
	output logic                       busy,
	input  wire req_t                  request,
	output logic                       result_valid,
	output res_t                       result,
	input  wire logic                  cfg_we,
	input  wire logic [CFG_IDX_W-1:0]  cfg_addr,
	input  wire logic [CFG_DATA_W-1:0] cfg_wdata
);

	logic      accept;
	ctrl_cmd_t cmd;
	ctrl_sts_t sts;

	assign accept = start && !busy;

	crt_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.accept (accept),
		.sts    (sts),
		.cmd    (cmd),
		.busy   (busy)
	);

	crt_datapath #(
		.TABLE_DEPTH (TABLE_DEPTH),
		.STACK_DEPTH (STACK_DEPTH)
	) u_datapath (
		.clk          (clk),
		.arst_n       (arst_n),
		.accept       (accept),
		.request      (request),
		.cfg_we       (cfg_we),
		.cfg_addr     (cfg_addr),
		.cfg_wdata    (cfg_wdata),
		.cmd          (cmd),
		.sts          (sts),
		.result       (result),
		.result_valid (result_valid)
	);

endmodule

`default_nettype wire
